// ----- rtl/core/magnetometer_heading_top_macros.svh -----
// assertion macros for the magnetometer heading block
`ifndef MAGNETOMETER_HEADING_TOP_MACROS_SVH
`define MAGNETOMETER_HEADING_TOP_MACROS_SVH

// same-cycle implication under reset
`define MHD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define MHD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mhd_pkg.sv -----
// shared types, constants and the arctangent table for the heading block
`timescale 1ns / 1ps
package mhd_pkg;

    localparam int XY_W      = 34;
    localparam int Z_W       = 26;
    localparam int ANG_W     = 28;
    localparam int IN_SHIFT  = 14;
    localparam int TABLE_LEN = 24;

    localparam logic signed [ANG_W-1:0] ANG_90  = ANG_W'(90 * 65536);
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(180 * 65536);
    localparam logic signed [ANG_W-1:0] ANG_360 = ANG_W'(360 * 65536);

    typedef struct packed {
        logic                   valid;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cell_data_t;

    // atan(2^-i) in degrees, scaled by 65536
    function automatic int atan_entry(input int idx);
        int r;
        begin
            case (idx)
                0:       r = 2949120;
                1:       r = 1740967;
                2:       r = 919879;
                3:       r = 466945;
                4:       r = 234379;
                5:       r = 117304;
                6:       r = 58666;
                7:       r = 29335;
                8:       r = 14668;
                9:       r = 7334;
                10:      r = 3667;
                11:      r = 1833;
                12:      r = 917;
                13:      r = 458;
                14:      r = 229;
                15:      r = 115;
                16:      r = 57;
                17:      r = 29;
                18:      r = 14;
                19:      r = 7;
                20:      r = 4;
                21:      r = 2;
                22:      r = 1;
                default: r = 0;
            endcase
            return r;
        end
    endfunction

endpackage

// ----- rtl/core/magnetometer_heading_top.sv -----
// top level of the magnetometer compass heading block
// usage:
//   input channel in_valid/in_ready carries one sample item: status_byte and
//   six little-endian data bytes. output channel out_valid/out_ready carries
//   x_value, y_value, z_value, heading (1/64 degree by default) and not_ready.
//   with status bit 0 set, the sample runs through a row of STEPS cordic cells
//   (CORDIC_STEPS, capped at TABLE_LEN), each a registered shift-add step; the
//   result waits in the held-result registers, then goes to the output register.
//   with bit 0 clear, the held values are marked pending on acceptance and then
//   go to the output register.
//   one item is in work at a time, so a new item is taken only after the last
//   one has moved on to the output register.
//   in_ready is high whenever no item is in work; a finished result may wait
//   in the output register while the next item is taken.
//   when the receiver stalls, out_valid and the fields hold until taken and
//   the item behind stays pending, so in_ready stays low.
//   reset clears the held x, y, z and heading to zero and empties the row.
`timescale 1ns / 1ps
`include "magnetometer_heading_top_macros.svh"
module magnetometer_heading_top
    import mhd_pkg::*;
#(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         status_byte,
    input  logic [7:0]         x_low,
    input  logic [7:0]         x_high,
    input  logic [7:0]         y_low,
    input  logic [7:0]         y_high,
    input  logic [7:0]         z_low,
    input  logic [7:0]         z_high,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] x_value,
    output logic signed [15:0] y_value,
    output logic signed [15:0] z_value,
    output logic [14:0]        heading,
    output logic               not_ready
);

    localparam int STEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
    localparam int H_FULL = 360 * (2 ** ANGLE_FRAC_BITS);
    localparam logic [14:0] H_LIMIT = (H_FULL > 32767) ? 15'h7fff : 15'(H_FULL);

    logic                    busy_reg;
    logic                    res_valid_reg;
    logic                    res_hold_reg;
    logic                    x_neg_reg;
    logic                    spec_reg;
    logic signed [ANG_W-1:0] spec_ang_reg;
    logic signed [15:0]      last_x_reg;
    logic signed [15:0]      last_y_reg;
    logic signed [15:0]      last_z_reg;
    logic [14:0]             last_heading_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      x_value_reg;
    logic signed [15:0]      y_value_reg;
    logic signed [15:0]      z_value_reg;
    logic [14:0]             heading_reg;
    logic                    not_ready_reg;

    logic                    accept;
    logic                    fresh;
    logic                    transfer;
    logic signed [15:0]      xv;
    logic signed [15:0]      yv;
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic                    spec_next;
    logic signed [ANG_W-1:0] spec_ang_next;
    logic [14:0]             heading_calc;
    cell_data_t              link [0:STEPS];

    assign accept   = in_valid && in_ready;
    assign fresh    = status_byte[0];
    assign transfer = res_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !busy_reg;

    assign xv = $signed({x_high, x_low});
    assign yv = $signed({y_high, y_low});

    always_comb
    begin
        xs = XY_W'(xv) <<< IN_SHIFT;
        ys = XY_W'(yv) <<< IN_SHIFT;
        if (xv < 0)
        begin
            xs = -xs;
            ys = -ys;
        end
        spec_next     = 1'b0;
        spec_ang_next = '0;
        if (yv == 0)
        begin
            spec_next     = 1'b1;
            spec_ang_next = (xv < 0) ? ANG_180 : '0;
        end
        else if (xv == 0)
        begin
            spec_next     = 1'b1;
            spec_ang_next = (yv > 0) ? ANG_90 : -ANG_90;
        end
    end

    assign link[0].valid = accept && fresh;
    assign link[0].x     = xs;
    assign link[0].y     = ys;
    assign link[0].z     = '0;

    genvar g;
    generate
        for (g = 0; g < STEPS; g++)
        begin : g_cell
            mhd_cell #(
                .STEP (g)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_in  (link[g]),
                .cell_out (link[g+1])
            );
        end
    endgenerate

    mhd_heading #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_heading (
        .z        (link[STEPS].z),
        .x_neg    (x_neg_reg),
        .spec     (spec_reg),
        .spec_ang (spec_ang_reg),
        .heading  (heading_calc)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_hold_reg     <= 1'b0;
            last_x_reg       <= '0;
            last_y_reg       <= '0;
            last_z_reg       <= '0;
            last_heading_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg     <= 1'b1;
                res_hold_reg <= !fresh;
                if (fresh)
                begin
                    last_x_reg <= xv;
                    last_y_reg <= yv;
                    last_z_reg <= $signed({z_high, z_low});
                end
                else
                begin
                    res_valid_reg <= 1'b1;
                end
            end
            if (link[STEPS].valid)
            begin
                last_heading_reg <= heading_calc;
                res_valid_reg    <= 1'b1;
            end
            if (transfer)
            begin
                res_valid_reg <= 1'b0;
                busy_reg      <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_neg_reg    <= (xv < 0);
            spec_reg     <= spec_next;
            spec_ang_reg <= spec_ang_next;
        end
        if (transfer)
        begin
            x_value_reg   <= last_x_reg;
            y_value_reg   <= last_y_reg;
            z_value_reg   <= last_z_reg;
            heading_reg   <= last_heading_reg;
            not_ready_reg <= res_hold_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign x_value   = x_value_reg;
    assign y_value   = y_value_reg;
    assign z_value   = z_value_reg;
    assign heading   = heading_reg;
    assign not_ready = not_ready_reg;

    `MHD_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, !in_ready, "ready high after accept")
    `MHD_ASSERT_NOW(a_tail_busy, clk, rst_n, link[STEPS].valid, busy_reg && !res_valid_reg, "cell row result without item in work")
    `MHD_ASSERT_NOW(a_res_busy, clk, rst_n, res_valid_reg, busy_reg, "pending result while idle")
    `MHD_ASSERT_NOW(a_head_range, clk, rst_n, out_valid, heading <= H_LIMIT, "heading beyond full turn")

endmodule

// ----- rtl/core/mhd_cell.sv -----
// one cordic vectoring cell with a fixed shift, registered toward its neighbor
`timescale 1ns / 1ps
module mhd_cell
    import mhd_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_data_t cell_in,
    output cell_data_t cell_out
);

    localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_entry(STEP));

    logic                   valid_reg;
    logic signed [XY_W-1:0] x_reg;
    logic signed [XY_W-1:0] y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic signed [XY_W-1:0] x_next;
    logic signed [XY_W-1:0] y_next;
    logic signed [Z_W-1:0]  z_next;
    logic signed [XY_W-1:0] sx;
    logic signed [XY_W-1:0] sy;

    always_comb
    begin
        sx = cell_in.x >>> STEP;
        sy = cell_in.y >>> STEP;
        if (cell_in.y > 0)
        begin
            x_next = cell_in.x + sy;
            y_next = cell_in.y - sx;
            z_next = cell_in.z + ATAN;
        end
        else
        begin
            x_next = cell_in.x - sy;
            y_next = cell_in.y + sx;
            z_next = cell_in.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign cell_out.valid = valid_reg;
    assign cell_out.x     = x_reg;
    assign cell_out.y     = y_reg;
    assign cell_out.z     = z_reg;

endmodule

// ----- rtl/core/mhd_heading.sv -----
// final angle fold, wrap into (0,360] degrees, rounding and saturation
`timescale 1ns / 1ps
module mhd_heading
    import mhd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 6
)
(
    input  logic signed [Z_W-1:0]   z,
    input  logic                    x_neg,
    input  logic                    spec,
    input  logic signed [ANG_W-1:0] spec_ang,
    output logic [14:0]             heading
);

    localparam int SH = 16 - ANGLE_FRAC_BITS;
    localparam logic signed [ANG_W-1:0] HALF = ANG_W'(2 ** (SH - 1));
    localparam logic signed [ANG_W-1:0] H_MAX = ANG_W'(32767);

    logic signed [ANG_W-1:0] a0;
    logic signed [ANG_W-1:0] a1;
    logic signed [ANG_W-1:0] a2;
    logic signed [ANG_W-1:0] h;

    always_comb
    begin
        if (spec)
            a0 = spec_ang;
        else
            a0 = ANG_W'(z) + (x_neg ? ANG_180 : '0);
        a1 = (a0 > ANG_180) ? a0 - ANG_360 : a0;
        a2 = (a1 <= 0) ? a1 + ANG_360 : a1;
        h  = (a2 + HALF) >>> SH;
        heading = (h > H_MAX) ? 15'h7fff : h[14:0];
    end

endmodule
